// ===== hw/rtl/pbr_pkg.sv =====
// Shared types, constants and the arctangent table for the pixel bearing
// and range pipeline. No dependencies.
package pbr_pkg;

  // Parameter defaults
  localparam int COORD_BITS_DEF    = 14;
  localparam int CORDIC_STAGES_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE  = 2'd2;

  // Register reset values
  localparam int WIDTH_RST  = 3000;
  localparam int HEIGHT_RST = 4000;
  localparam int SCALE_RST  = 63401;

  // Field widths
  localparam int SCALE_W    = 24;
  localparam int SCALE_HALF = 12;
  localparam int BEARING_W  = 15;
  localparam int RANGE_W    = 23;

  // Angles in 2^-16 degree
  localparam int Z_W   = 24;
  localparam int ATN_W = 23;
  localparam int ANG_W = 25;
  localparam logic [ANG_W-1:0] DEG90  = 25'd5898240;
  localparam logic [ANG_W-1:0] DEG180 = 25'd11796480;
  localparam logic [ANG_W-1:0] DEG360 = 25'd23592960;

  // Output rounding and limits
  localparam int ROUND_HALF   = 512;
  localparam int ROUND_SHIFT  = 10;
  localparam int BEARING_WRAP = 23040;
  localparam int RANGE_MAX    = 8388607;
  localparam int RANGE_SHIFT  = 24;

  // Offsets are scaled by 2^8 on entry to the angle and distance units
  localparam int FRAC_BITS = 8;

  typedef struct packed {
    logic oof;
    logic bx_neg;
    logic by_neg;
    logic ax_zero;
    logic ay_zero;
  } flags_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  function automatic logic [ATN_W-1:0] atan_lookup(input logic [4:0] idx);
    logic [ATN_W-1:0] val;
    unique case (idx)
      5'd0:    val = 23'd2949120;
      5'd1:    val = 23'd1740967;
      5'd2:    val = 23'd919879;
      5'd3:    val = 23'd466945;
      5'd4:    val = 23'd234379;
      5'd5:    val = 23'd117304;
      5'd6:    val = 23'd58666;
      5'd7:    val = 23'd29335;
      5'd8:    val = 23'd14668;
      5'd9:    val = 23'd7334;
      5'd10:   val = 23'd3667;
      5'd11:   val = 23'd1833;
      5'd12:   val = 23'd917;
      5'd13:   val = 23'd458;
      5'd14:   val = 23'd229;
      5'd15:   val = 23'd115;
      5'd16:   val = 23'd57;
      5'd17:   val = 23'd29;
      5'd18:   val = 23'd14;
      5'd19:   val = 23'd7;
      5'd20:   val = 23'd4;
      5'd21:   val = 23'd2;
      5'd22:   val = 23'd1;
      default: val = 23'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/pbr_front.sv =====
// Entry stages: frame check, mirroring, centre offsets, then squared distance
// and the starting vector for the cell chain. Uses pbr_pkg.
module pbr_front #(
  parameter int COORD_BITS = pbr_pkg::COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [COORD_BITS-1:0]    pixel_x_i,
  input  logic [COORD_BITS-1:0]    pixel_y_i,
  input  logic [COORD_BITS-1:0]    width_i,
  input  logic [COORD_BITS-1:0]    height_i,
  output logic                     valid_o,
  output pbr_pkg::flags_t          flags_o,
  output logic signed [COORD_BITS+10:0] x_o,
  output logic signed [COORD_BITS+10:0] y_o,
  output logic [2*COORD_BITS+17:0] rad_o
);

  localparam int C    = COORD_BITS;
  localparam int XW   = C + 11;
  localparam int D2_W = 2 * C + 1;
  localparam int NW   = 2 * C + 18;

  // stage A
  logic                  a_valid_q;
  pbr_pkg::flags_t       a_flags_d, a_flags_q;
  logic [C-1:0]          ax_d, ax_q, ay_d, ay_q;
  logic                  xm_zero_d, xm_zero_q;
  logic [C-1:0]          xm, cx, cy;
  logic signed [C:0]     bx, by;

  always_comb begin
    xm = width_i - pixel_x_i;
    cx = width_i >> 1;
    cy = height_i >> 1;
    bx = $signed({1'b0, cx}) - $signed({1'b0, xm});
    by = $signed({1'b0, cy}) - $signed({1'b0, pixel_y_i});
    ax_d = bx[C] ? C'(-bx) : bx[C-1:0];
    ay_d = by[C] ? C'(-by) : by[C-1:0];
    xm_zero_d = (xm == '0);
    a_flags_d.oof     = (width_i == '0) || (height_i == '0) ||
                        (pixel_x_i > width_i) || (pixel_y_i > height_i);
    a_flags_d.bx_neg  = bx[C];
    a_flags_d.by_neg  = by[C];
    a_flags_d.ax_zero = (ax_d == '0);
    a_flags_d.ay_zero = (ay_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      valid_o   <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q      <= ax_d;
    ay_q      <= ay_d;
    xm_zero_q <= xm_zero_d;
    a_flags_q <= a_flags_d;
  end

  // stage B: a mirrored column of zero counts only the vertical offset
  logic [2*C-1:0] ax_ext, ay_ext, sqx, sqy;
  logic [D2_W-1:0] d2;

  always_comb begin
    ax_ext = (2*C)'(ax_q);
    ay_ext = (2*C)'(ay_q);
    sqx    = xm_zero_q ? '0 : ax_ext * ax_ext;
    sqy    = ay_ext * ay_ext;
    d2     = {1'b0, sqx} + {1'b0, sqy};
  end

  always_ff @(posedge clk_i) begin
    flags_o <= a_flags_q;
    x_o     <= $signed(XW'({ax_q, {pbr_pkg::FRAC_BITS{1'b0}}}));
    y_o     <= $signed(XW'({ay_q, {pbr_pkg::FRAC_BITS{1'b0}}}));
    rad_o   <= NW'({d2, 16'b0});
  end

endmodule

// ===== hw/rtl/pbr_cell.sv =====
// One link: a CORDIC vectoring micro-rotation if IDX < CORDIC_STAGES and one root
// digit of the distance square root if IDX < SQ, both registered. Uses pbr_pkg.
module pbr_cell #(
  parameter int COORD_BITS    = pbr_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = pbr_pkg::CORDIC_STAGES_DEF,
  parameter int IDX           = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  pbr_pkg::flags_t               flags_i,
  input  logic signed [COORD_BITS+10:0] x_i,
  input  logic signed [COORD_BITS+10:0] y_i,
  input  logic signed [pbr_pkg::Z_W-1:0] z_i,
  input  logic [2*COORD_BITS+17:0]      rad_i,
  input  logic [COORD_BITS+10:0]        rem_i,
  input  logic [COORD_BITS+8:0]         root_i,
  output logic                          valid_o,
  output pbr_pkg::flags_t               flags_o,
  output logic signed [COORD_BITS+10:0] x_o,
  output logic signed [COORD_BITS+10:0] y_o,
  output logic signed [pbr_pkg::Z_W-1:0] z_o,
  output logic [2*COORD_BITS+17:0]      rad_o,
  output logic [COORD_BITS+10:0]        rem_o,
  output logic [COORD_BITS+8:0]         root_o
);

  localparam int  SQ     = COORD_BITS + 9;
  localparam int  NW     = 2 * SQ;
  localparam int  RW     = SQ + 2;
  localparam int  XW     = COORD_BITS + 11;
  localparam bit  ROT_EN = (IDX < CORDIC_STAGES);
  localparam bit  SQ_EN  = (IDX < SQ);

  logic signed [XW-1:0]           xs, ys, x_d, y_d;
  logic signed [pbr_pkg::Z_W-1:0] atn, z_d;
  logic [RW-1:0]                  trial, sub, rem_d;
  logic [SQ-1:0]                  root_d;
  logic [NW-1:0]                  rad_d;

  always_comb begin
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    atn = $signed(pbr_pkg::Z_W'(pbr_pkg::atan_lookup(5'(IDX))));
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (ROT_EN) begin
      // rotate clockwise while y is not negative
      if (!y_i[XW-1]) begin
        x_d = x_i + ys;
        y_d = y_i - xs;
        z_d = z_i + atn;
      end else begin
        x_d = x_i - ys;
        y_d = y_i + xs;
        z_d = z_i - atn;
      end
    end

    trial  = {rem_i[RW-3:0], rad_i[NW-1:NW-2]};
    sub    = {root_i, 2'b01};
    rem_d  = rem_i;
    root_d = root_i;
    rad_d  = rad_i;
    if (SQ_EN) begin
      rad_d = rad_i << 2;
      if (trial >= sub) begin
        rem_d  = trial - sub;
        root_d = {root_i[SQ-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        root_d = {root_i[SQ-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_o <= flags_i;
    x_o     <= x_d;
    y_o     <= y_d;
    z_o     <= z_d;
    rad_o   <= rad_d;
    rem_o   <= rem_d;
    root_o  <= root_d;
  end

endmodule

// ===== hw/rtl/pbr_back.sv =====
// Exit stages: quadrant mapping and rounding of the bearing, range scaling in
// two partial products, saturation and the result registers. Uses pbr_pkg.
module pbr_back #(
  parameter int COORD_BITS = pbr_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  pbr_pkg::flags_t                 flags_i,
  input  logic signed [pbr_pkg::Z_W-1:0]  z_i,
  input  logic [COORD_BITS+8:0]           root_i,
  input  logic [pbr_pkg::SCALE_W-1:0]     scale_i,
  output logic                            done_o,
  output logic [pbr_pkg::BEARING_W-1:0]   bearing_o,
  output logic [pbr_pkg::RANGE_W-1:0]     ground_range_o,
  output logic                            out_of_frame_o
);

  localparam int SQ    = COORD_BITS + 9;
  localparam int PW    = SQ + pbr_pkg::SCALE_HALF;
  localparam int SUM_W = SQ + pbr_pkg::SCALE_W + 1;
  localparam int ANG_W = pbr_pkg::ANG_W;
  localparam int HALF  = pbr_pkg::SCALE_HALF;

  // stage C
  logic             c_valid_q, c_oof_q;
  logic [ANG_W-1:0] a_clamp, ang_d, ang_q;
  logic [PW-1:0]    phi_d, plo_d, phi_q, plo_q;

  always_comb begin
    if (z_i[pbr_pkg::Z_W-1]) begin
      a_clamp = '0;
    end else if (ANG_W'(z_i) > pbr_pkg::DEG90) begin
      a_clamp = pbr_pkg::DEG90;
    end else begin
      a_clamp = ANG_W'(z_i);
    end
    // exact answers on the axes and at the centre
    if (flags_i.ay_zero) begin
      a_clamp = '0;
    end else if (flags_i.ax_zero) begin
      a_clamp = pbr_pkg::DEG90;
    end
    unique case ({flags_i.bx_neg, flags_i.by_neg})
      2'b10:   ang_d = pbr_pkg::DEG180 - a_clamp;
      2'b11:   ang_d = pbr_pkg::DEG180 + a_clamp;
      2'b01:   ang_d = pbr_pkg::DEG360 - a_clamp;
      default: ang_d = a_clamp;
    endcase
    phi_d = PW'(root_i) * PW'(scale_i[pbr_pkg::SCALE_W-1:HALF]);
    plo_d = PW'(root_i) * PW'(scale_i[HALF-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      c_valid_q <= valid_i;
      done_o    <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_oof_q <= flags_i.oof;
    ang_q   <= ang_d;
    phi_q   <= phi_d;
    plo_q   <= plo_d;
  end

  // stage D
  logic [ANG_W:0]    brg_sum;
  logic [15:0]       brg_full;
  logic [SUM_W-1:0]  rng_sum;
  logic [SQ:0]       rng_sh;
  logic [pbr_pkg::BEARING_W-1:0] bearing_d;
  logic [pbr_pkg::RANGE_W-1:0]   range_d;

  always_comb begin
    brg_sum  = {1'b0, ang_q} + (ANG_W+1)'(pbr_pkg::ROUND_HALF);
    brg_full = 16'(brg_sum >> pbr_pkg::ROUND_SHIFT);
    // a full turn after rounding wraps to zero
    if (brg_full >= 16'(pbr_pkg::BEARING_WRAP)) begin
      bearing_d = '0;
    end else begin
      bearing_d = brg_full[pbr_pkg::BEARING_W-1:0];
    end

    rng_sum = (SUM_W'(phi_q) << HALF) + SUM_W'(plo_q) +
              (SUM_W'(1) << (pbr_pkg::RANGE_SHIFT - 1));
    rng_sh  = rng_sum[SUM_W-1:pbr_pkg::RANGE_SHIFT];
    if (32'(rng_sh) > 32'(pbr_pkg::RANGE_MAX)) begin
      range_d = pbr_pkg::RANGE_W'(pbr_pkg::RANGE_MAX);
    end else begin
      range_d = pbr_pkg::RANGE_W'(rng_sh);
    end

    if (c_oof_q) begin
      bearing_d = '0;
      range_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    bearing_o      <= bearing_d;
    ground_range_o <= range_d;
    out_of_frame_o <= c_oof_q;
  end

endmodule

// ===== hw/rtl/pixel_bearing_and_range.sv =====
// Pixel bearing and ground range: frame check, a chain of CORDIC/square-root
// cells and a scaling back end. Uses pbr_pkg, pbr_front, pbr_cell, pbr_back.
// Each item passes front stages A and B, a chain of CELLS cells, where CELLS is
// the larger of CORDIC_STAGES and COORD_BITS + 9, and back stages C and D.
// Throughput: one item per cycle; busy_o stays low, the pipeline never stalls.
// Results are strobed by done_o for one cycle and cannot be held off.
// Reset clears the pipeline valid bits and loads the register defaults.
module pixel_bearing_and_range #(
  parameter int COORD_BITS    = pbr_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = pbr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pbr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pbr_pkg::SCALE_W-1:0]     cfg_data_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [COORD_BITS-1:0]           pixel_x_i,
  input  logic [COORD_BITS-1:0]           pixel_y_i,
  output logic                            done_o,
  output logic [pbr_pkg::BEARING_W-1:0]   bearing_o,
  output logic [pbr_pkg::RANGE_W-1:0]     ground_range_o,
  output logic                            out_of_frame_o
);

  localparam int SQ    = COORD_BITS + 9;
  localparam int XW    = COORD_BITS + 11;
  localparam int NW    = 2 * SQ;
  localparam int RW    = SQ + 2;
  localparam int CELLS = (CORDIC_STAGES > SQ) ? CORDIC_STAGES : SQ;

  // configuration registers
  logic [COORD_BITS-1:0]        width_q, height_q;
  logic [pbr_pkg::SCALE_W-1:0]  scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= COORD_BITS'(pbr_pkg::WIDTH_RST);
      height_q <= COORD_BITS'(pbr_pkg::HEIGHT_RST);
      scale_q  <= pbr_pkg::SCALE_W'(pbr_pkg::SCALE_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbr_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[COORD_BITS-1:0];
        pbr_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i[COORD_BITS-1:0];
        pbr_pkg::REG_RANGE_SCALE:  scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // chain links
  logic                           valid_c [CELLS+1];
  pbr_pkg::flags_t                flags_c [CELLS+1];
  logic signed [XW-1:0]           x_c     [CELLS+1];
  logic signed [XW-1:0]           y_c     [CELLS+1];
  logic signed [pbr_pkg::Z_W-1:0] z_c     [CELLS+1];
  logic [NW-1:0]                  rad_c   [CELLS+1];
  logic [RW-1:0]                  rem_c   [CELLS+1];
  logic [SQ-1:0]                  root_c  [CELLS+1];

  pbr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_o),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .width_i   (width_q),
    .height_i  (height_q),
    .valid_o   (valid_c[0]),
    .flags_o   (flags_c[0]),
    .x_o       (x_c[0]),
    .y_o       (y_c[0]),
    .rad_o     (rad_c[0])
  );

  assign z_c[0]    = '0;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    pbr_cell #(
      .COORD_BITS    (COORD_BITS),
      .CORDIC_STAGES (CORDIC_STAGES),
      .IDX           (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .flags_i (flags_c[i]),
      .x_i     (x_c[i]),
      .y_i     (y_c[i]),
      .z_i     (z_c[i]),
      .rad_i   (rad_c[i]),
      .rem_i   (rem_c[i]),
      .root_i  (root_c[i]),
      .valid_o (valid_c[i+1]),
      .flags_o (flags_c[i+1]),
      .x_o     (x_c[i+1]),
      .y_o     (y_c[i+1]),
      .z_o     (z_c[i+1]),
      .rad_o   (rad_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .root_o  (root_c[i+1])
    );
  end

  pbr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_c[CELLS]),
    .flags_i        (flags_c[CELLS]),
    .z_i            (z_c[CELLS]),
    .root_i         (root_c[CELLS]),
    .scale_i        (scale_q),
    .done_o         (done_o),
    .bearing_o      (bearing_o),
    .ground_range_o (ground_range_o),
    .out_of_frame_o (out_of_frame_o)
  );

endmodule
